@@ hdl/zsbf_pkg.sv @@
// Shared constants and the item descriptor of the zlib stored-block framer.
package zsbf_pkg;

  // Largest payload of one stored block.
  localparam logic [31:0] MaxBlock = 32'd65535;
  // Adler-32 modulus.
  localparam logic [16:0] AdlerMod = 17'd65521;
  // zlib header bytes.
  localparam logic [7:0] ZlibCmf = 8'h78;
  localparam logic [7:0] ZlibFlg = 8'h01;
  // Reset value of the total length register.
  localparam logic [31:0] TotalLenReset = 32'd1;

  // Descriptor queue between the front and back parts.
  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);

  // Output byte positions within the results of one item.
  localparam logic [3:0] PosZ0   = 4'd0;
  localparam logic [3:0] PosZ1   = 4'd1;
  localparam logic [3:0] PosB0   = 4'd2;
  localparam logic [3:0] PosB1   = 4'd3;
  localparam logic [3:0] PosB2   = 4'd4;
  localparam logic [3:0] PosB3   = 4'd5;
  localparam logic [3:0] PosB4   = 4'd6;
  localparam logic [3:0] PosData = 4'd7;
  localparam logic [3:0] PosT0   = 4'd8;
  localparam logic [3:0] PosT1   = 4'd9;
  localparam logic [3:0] PosT2   = 4'd10;
  localparam logic [3:0] PosT3   = 4'd11;

  // Everything the back part needs to emit the results of one item.
  typedef struct packed {
    logic [7:0]  data;
    logic        zhdr;
    logic        bhdr;
    logic        bfinal;
    logic [15:0] chunk;
    logic        trl;
    logic [15:0] adler_high;
    logic [15:0] adler_low;
  } desc_t;

endpackage

@@ hdl/zsbf_front.sv @@
// Front part: accepts payload bytes, tracks stream state and builds descriptors.
module zsbf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_total_length,
  input  logic                push,
  input  logic                fifo_full,
  input  logic [7:0]          in_data_byte,
  output logic                wr_en,
  output zsbf_pkg::desc_t     wr_desc
);

  logic [31:0] total_len_r;
  logic [15:0] adler_low_r, adler_low_nxt;
  logic [15:0] adler_high_r, adler_high_nxt;
  logic [31:0] consumed_r, consumed_nxt;
  logic [15:0] left_r, left_nxt;

  logic [31:0] eff;
  logic [31:0] remaining;
  logic [15:0] chunk;
  logic        bfinal;
  logic [16:0] low_sum, low_mod;
  logic [16:0] high_sum, high_mod;
  logic [31:0] consumed_inc;
  logic        stream_end;

  assign wr_en = push && !fifo_full;

  // Classify the item against the stream state
  always_comb begin
    eff          = (total_len_r == 32'd0) ? 32'd1 : total_len_r;
    remaining    = (eff > consumed_r) ? (eff - consumed_r) : 32'd1;
    bfinal       = (remaining <= zsbf_pkg::MaxBlock);
    chunk        = bfinal ? remaining[15:0] : zsbf_pkg::MaxBlock[15:0];
    low_sum      = {1'b0, adler_low_r} + {9'b0, in_data_byte};
    low_mod      = (low_sum >= zsbf_pkg::AdlerMod) ? (low_sum - zsbf_pkg::AdlerMod) : low_sum;
    high_sum     = {1'b0, adler_high_r} + {1'b0, low_mod[15:0]};
    high_mod     = (high_sum >= zsbf_pkg::AdlerMod) ? (high_sum - zsbf_pkg::AdlerMod)
                                                    : high_sum;
    consumed_inc = consumed_r + 32'd1;
    stream_end   = (consumed_inc >= eff);
  end

  // Build the descriptor
  always_comb begin
    wr_desc.data       = in_data_byte;
    wr_desc.zhdr       = (consumed_r == 32'd0);
    wr_desc.bhdr       = (left_r == 16'd0);
    wr_desc.bfinal     = bfinal;
    wr_desc.chunk      = chunk;
    wr_desc.trl        = stream_end;
    wr_desc.adler_high = high_mod[15:0];
    wr_desc.adler_low  = low_mod[15:0];
  end

  // Advance the stream state; clear it after the trailer
  always_comb begin
    if (stream_end) begin
      adler_low_nxt  = 16'd1;
      adler_high_nxt = 16'd0;
      consumed_nxt   = 32'd0;
      left_nxt       = 16'd0;
    end else begin
      adler_low_nxt  = low_mod[15:0];
      adler_high_nxt = high_mod[15:0];
      consumed_nxt   = consumed_inc;
      left_nxt       = ((left_r == 16'd0) ? chunk : left_r) - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_len_r  <= zsbf_pkg::TotalLenReset;
      adler_low_r  <= 16'd1;
      adler_high_r <= 16'd0;
      consumed_r   <= 32'd0;
      left_r       <= 16'd0;
    end else begin
      if (cfg_wr_en) begin
        total_len_r <= cfg_total_length;
      end
      if (wr_en) begin
        adler_low_r  <= adler_low_nxt;
        adler_high_r <= adler_high_nxt;
        consumed_r   <= consumed_nxt;
        left_r       <= left_nxt;
      end
    end
  end

endmodule

@@ hdl/zsbf_fifo.sv @@
// Short descriptor queue between the front and back parts.
module zsbf_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  zsbf_pkg::desc_t     wr_desc,
  input  logic                rd_en,
  output zsbf_pkg::desc_t     rd_desc,
  output logic                full,
  output logic                empty
);

  zsbf_pkg::desc_t                   mem_r [zsbf_pkg::FifoDepth];
  logic [zsbf_pkg::FifoAw-1:0]       wr_ptr_r;
  logic [zsbf_pkg::FifoAw-1:0]       rd_ptr_r;
  logic [zsbf_pkg::FifoAw:0]         cnt_r, cnt_nxt;

  assign full    = (cnt_r == (zsbf_pkg::FifoAw + 1)'(zsbf_pkg::FifoDepth));
  assign empty   = (cnt_r == '0);
  assign rd_desc = mem_r[rd_ptr_r];

  // Track the fill level
  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Store descriptors
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ hdl/zsbf_back.sv @@
// Back part: walks each descriptor and sends its stream bytes to the output register.
module zsbf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  zsbf_pkg::desc_t     rd_desc,
  input  logic                fifo_empty,
  output logic                rd_en,
  input  logic                pop,
  output logic                empty,
  output logic [7:0]          out_byte,
  output logic                out_last_of_run,
  output logic                out_end_of_stream
);

  logic       active_r;
  logic [3:0] pos_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_eos_r;

  logic [3:0] start_pos;
  logic [3:0] cur_pos;
  logic [3:0] pos_nxt;
  logic       is_last;
  logic       slot_free;
  logic       emit;
  logic [7:0] byte_sel;
  logic [15:0] nchunk;

  assign empty             = !out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_last_of_run   = out_last_r;
  assign out_end_of_stream = out_eos_r;

  assign slot_free = !out_valid_r || pop;
  assign emit      = !fifo_empty && slot_free;
  assign rd_en     = emit && is_last;
  assign nchunk    = ~rd_desc.chunk;

  // Pick the position of the byte to send
  always_comb begin
    if (rd_desc.zhdr) begin
      start_pos = zsbf_pkg::PosZ0;
    end else if (rd_desc.bhdr) begin
      start_pos = zsbf_pkg::PosB0;
    end else begin
      start_pos = zsbf_pkg::PosData;
    end
    cur_pos = active_r ? pos_r : start_pos;
  end

  // Step to the next position; flag the last byte of the item
  always_comb begin
    is_last = 1'b0;
    case (cur_pos)
      zsbf_pkg::PosZ1: begin
        pos_nxt = rd_desc.bhdr ? zsbf_pkg::PosB0 : zsbf_pkg::PosData;
      end
      zsbf_pkg::PosB4: begin
        pos_nxt = zsbf_pkg::PosData;
      end
      zsbf_pkg::PosData: begin
        pos_nxt = zsbf_pkg::PosT0;
        is_last = !rd_desc.trl;
      end
      zsbf_pkg::PosT3: begin
        pos_nxt = zsbf_pkg::PosZ0;
        is_last = 1'b1;
      end
      default: begin
        pos_nxt = cur_pos + 4'd1;
      end
    endcase
  end

  // Select the byte for the current position
  always_comb begin
    case (cur_pos)
      zsbf_pkg::PosZ0:   byte_sel = zsbf_pkg::ZlibCmf;
      zsbf_pkg::PosZ1:   byte_sel = zsbf_pkg::ZlibFlg;
      zsbf_pkg::PosB0:   byte_sel = {7'b0, rd_desc.bfinal};
      zsbf_pkg::PosB1:   byte_sel = rd_desc.chunk[7:0];
      zsbf_pkg::PosB2:   byte_sel = rd_desc.chunk[15:8];
      zsbf_pkg::PosB3:   byte_sel = nchunk[7:0];
      zsbf_pkg::PosB4:   byte_sel = nchunk[15:8];
      zsbf_pkg::PosData: byte_sel = rd_desc.data;
      zsbf_pkg::PosT0:   byte_sel = rd_desc.adler_high[15:8];
      zsbf_pkg::PosT1:   byte_sel = rd_desc.adler_high[7:0];
      zsbf_pkg::PosT2:   byte_sel = rd_desc.adler_low[15:8];
      zsbf_pkg::PosT3:   byte_sel = rd_desc.adler_low[7:0];
      default:           byte_sel = 8'h00;
    endcase
  end

  // Load the output register; drop the descriptor after its last byte
  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= byte_sel;
      out_last_r <= is_last;
      out_eos_r  <= (cur_pos == zsbf_pkg::PosT3);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      pos_r       <= zsbf_pkg::PosZ0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        active_r    <= !is_last;
        pos_r       <= pos_nxt;
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // An item in progress always has its descriptor at the queue head
  a_active_has_desc: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> !fifo_empty)
    else $error("back part active with an empty descriptor queue");

  // The trailer end closes the item
  a_eos_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_eos_r) |-> out_last_r)
    else $error("end of stream without last of run");

  // A descriptor leaves the queue only on a transfer into the output register
  a_pop_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> (out_valid_r && out_last_r))
    else $error("descriptor dropped without its last byte");

  // Payload byte sent mid-item keeps the walk going toward the trailer
  a_trl_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && cur_pos == zsbf_pkg::PosData && rd_desc.trl) |=> (active_r && pos_r == zsbf_pkg::PosT0))
    else $error("trailer not started after the final payload byte");

endmodule

@@ hdl/zlib_stored_block_framer.sv @@
// Top level of the zlib stored-block framer: front part, descriptor queue, back part.
//
// Payload bytes pushed in come out wrapped as a zlib stream of stored blocks:
// the header 78 01 ahead of the first byte, a five-byte block header
// (BFINAL, LEN, NLEN) every 65535 bytes, and the Adler-32 big-endian after
// the byte that reaches total_length (0 counts as 1). Each payload byte is one
// output byte, so with pop held high a long stream runs at one payload byte
// per cycle apart from the header and trailer bytes. The rate is set by the
// single output register, which sends one stream byte per cycle while pop is
// high and a descriptor waits; a four-entry descriptor queue lets push keep
// going while the back part sends header and trailer bytes. The first byte of
// an item passes through the queue and then the output register. total_length
// is to be written by the user only while the block is idle; the block does
// not enforce this. A write takes effect on the next byte.
module zlib_stored_block_framer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_total_length,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_last_of_run,
  output logic        out_end_of_stream
);

  logic            wr_en;
  logic            rd_en;
  logic            fifo_empty;
  zsbf_pkg::desc_t wr_desc;
  zsbf_pkg::desc_t rd_desc;

  zsbf_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_total_length (cfg_total_length),
    .push             (push),
    .fifo_full        (full),
    .in_data_byte     (in_data_byte),
    .wr_en            (wr_en),
    .wr_desc          (wr_desc)
  );

  zsbf_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_desc (wr_desc),
    .rd_en   (rd_en),
    .rd_desc (rd_desc),
    .full    (full),
    .empty   (fifo_empty)
  );

  zsbf_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .rd_desc           (rd_desc),
    .fifo_empty        (fifo_empty),
    .rd_en             (rd_en),
    .pop               (pop),
    .empty             (empty),
    .out_byte          (out_byte),
    .out_last_of_run   (out_last_of_run),
    .out_end_of_stream (out_end_of_stream)
  );

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the zlib stored-block framer: queued byte driver, checking monitor.
module testbench;

  localparam int LimitCycles = 1000000;
  localparam int MaxWait     = 16;
  localparam int RandomItems = 90;

  // Idle modes for either side of the block.
  localparam int IdleNone  = 0;
  localparam int IdleAlways = 1;
  localparam int IdleMixed = 2;

  // One byte of the zlib stream as the block should send it.
  typedef struct packed {
    logic [7:0] value;
    logic       last_of_run;
    logic       end_of_stream;
  } zbyte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_total_length = '0;
  logic        push = 1'b0;
  logic [7:0]  in_data_byte = '0;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic [7:0]  out_byte;
  logic        out_last_of_run;
  logic        out_end_of_stream;

  // Framing state of the stream as the block should see it.
  logic [31:0] frame_total = zsbf_pkg::TotalLenReset;
  logic [31:0] frame_consumed = '0;
  logic [15:0] block_left = '0;
  logic [15:0] adler_lo = 16'd1;
  logic [15:0] adler_hi = '0;

  logic [7:0] payload_q [$];
  zbyte_t     expected_bytes [$];

  int gap_mode = IdleMixed;
  int stall_mode = IdleMixed;
  int wait_left = 0;
  int stall_left = 0;
  int errors = 0;
  int bytes_sent = 0;
  int bytes_checked = 0;
  int streams_done = 0;
  int length_writes = 0;
  int cycles = 0;

  zlib_stored_block_framer DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_total_length  (cfg_total_length),
    .push              (push),
    .full              (full),
    .in_data_byte      (in_data_byte),
    .empty             (empty),
    .pop               (pop),
    .out_byte          (out_byte),
    .out_last_of_run   (out_last_of_run),
    .out_end_of_stream (out_end_of_stream)
  );

  always #5 clk = ~clk;

  // Draw the number of idle cycles ahead of the next transfer.
  function automatic int draw_wait(input int mode);
    case (mode)
      IdleNone:   return 0;
      IdleAlways: return $urandom_range(0, MaxWait);
      default:    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MaxWait) : 0;
    endcase
  endfunction

  // Pick a payload byte, leaning on the all-zero and all-one values.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_byte(input logic [7:0] value);
    expected_bytes.push_back('{value: value, last_of_run: 1'b0, end_of_stream: 1'b0});
  endfunction

  // Frame one payload byte: headers, pass-through, Adler-32 update and trailer.
  task automatic frame_byte(input logic [7:0] b);
    logic [31:0] eff;
    logic [31:0] remaining;
    logic [31:0] chunk;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [15:0] nlen;
    logic        ended;
    zbyte_t      tail;
    eff = (frame_total == 32'd0) ? 32'd1 : frame_total;
    if (frame_consumed == 32'd0) begin
      add_byte(zsbf_pkg::ZlibCmf);
      add_byte(zsbf_pkg::ZlibFlg);
    end
    // Open a stored block: BFINAL, LEN and NLEN little-endian.
    if (block_left == 16'd0) begin
      remaining = (eff > frame_consumed) ? eff - frame_consumed : 32'd1;
      chunk = (remaining > zsbf_pkg::MaxBlock) ? zsbf_pkg::MaxBlock : remaining;
      nlen = ~chunk[15:0];
      add_byte({7'd0, chunk == remaining});
      add_byte(chunk[7:0]);
      add_byte(chunk[15:8]);
      add_byte(nlen[7:0]);
      add_byte(nlen[15:8]);
      block_left = chunk[15:0];
    end
    add_byte(b);
    lo = {16'd0, adler_lo} + {24'd0, b};
    if (lo >= {15'd0, zsbf_pkg::AdlerMod}) lo = lo - {15'd0, zsbf_pkg::AdlerMod};
    hi = {16'd0, adler_hi} + lo;
    if (hi >= {15'd0, zsbf_pkg::AdlerMod}) hi = hi - {15'd0, zsbf_pkg::AdlerMod};
    adler_lo = lo[15:0];
    adler_hi = hi[15:0];
    frame_consumed = frame_consumed + 32'd1;
    block_left = block_left - 16'd1;
    ended = (frame_consumed >= eff);
    // Close the stream with the checksum, high sum first, and start over.
    if (ended) begin
      add_byte(adler_hi[15:8]);
      add_byte(adler_hi[7:0]);
      add_byte(adler_lo[15:8]);
      add_byte(adler_lo[7:0]);
      adler_lo = 16'd1;
      adler_hi = '0;
      frame_consumed = '0;
      block_left = '0;
      streams_done++;
    end
    tail = expected_bytes.pop_back();
    tail.last_of_run = 1'b1;
    tail.end_of_stream = ended;
    expected_bytes.push_back(tail);
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("MISMATCH at stream byte %0d: %s, got %0h expected %0h",
             bytes_checked, what, got, want);
    errors++;
  endtask

  // Hold until every queued byte is sent and every expected result has arrived.
  task automatic wait_drained();
    do @(negedge clk);
    while (payload_q.size() != 0 || push || expected_bytes.size() != 0);
  endtask

  // Write the total length once the block is idle.
  task automatic set_length(input logic [31:0] len);
    wait_drained();
    repeat (8) @(negedge clk);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_total_length <= len;
    frame_total = len;
    length_writes++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Driver: present queued bytes, hold each until its transfer.
  always @(posedge clk) begin : feed
    logic       next_push;
    logic [7:0] next_byte;
    if (!rst_n) begin
      push <= 1'b0;
      in_data_byte <= '0;
      wait_left = 0;
    end else begin
      next_push = push;
      next_byte = in_data_byte;
      if (push && !full) begin
        frame_byte(in_data_byte);
        bytes_sent++;
        next_push = 1'b0;
      end
      if (!next_push) begin
        if (wait_left > 0) begin
          wait_left--;
        end else if (payload_q.size() != 0) begin
          next_push = 1'b1;
          next_byte = payload_q.pop_front();
          wait_left = draw_wait(gap_mode);
        end
      end
      push <= next_push;
      in_data_byte <= next_byte;
    end
  end

  // Monitor: check each transfer against the oldest expected byte.
  always @(posedge clk) begin : watch
    zbyte_t want;
    logic   next_pop;
    if (!rst_n) begin
      pop <= 1'b0;
      stall_left = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("byte with nothing expected", out_byte, 8'h00);
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.value)
            report_mismatch("out_byte", out_byte, want.value);
          if (out_last_of_run !== want.last_of_run)
            report_mismatch("out_last_of_run", {7'd0, out_last_of_run}, {7'd0, want.last_of_run});
          if (out_end_of_stream !== want.end_of_stream)
            report_mismatch("out_end_of_stream", {7'd0, out_end_of_stream},
                            {7'd0, want.end_of_stream});
        end
        bytes_checked++;
        stall_left = draw_wait(stall_mode);
      end
      if (stall_left > 0) begin
        next_pop = 1'b0;
        stall_left--;
      end else begin
        next_pop = 1'b1;
      end
      pop <= next_pop;
    end
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("timeout after %0d cycles, %0d bytes still expected", cycles,
               expected_bytes.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned len;
    int          n;
    int          k;
    int          random_items;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset length of one: every byte is a stream of its own.
    payload_q.push_back(8'h00);
    payload_q.push_back(8'hFF);
    payload_q.push_back(8'hA5);
    payload_q.push_back(8'h5A);

    // Zero length counts as one.
    set_length(32'd0);
    payload_q.push_back(8'h01);
    payload_q.push_back(8'h80);

    // Five-byte streams; pause mid-stream until the output has drained.
    set_length(32'd5);
    for (int i = 0; i < 3; i++) payload_q.push_back(pick_byte());
    wait_drained();
    for (int i = 0; i < 4; i++) payload_q.push_back(pick_byte());

    // Close the open stream, spend a final block, lengthen the stream, then
    // shrink it below the bytes sent: the next block gets LEN 1, final.
    set_length(32'd3);
    payload_q.push_back(pick_byte());
    set_length(32'd2);
    payload_q.push_back(pick_byte());
    set_length(32'd10);
    payload_q.push_back(8'hFF);
    set_length(32'd2);
    payload_q.push_back(8'h00);

    // Largest length, then cut the open stream short.
    set_length(32'hFFFF_FFFF);
    for (int i = 0; i < 3; i++) payload_q.push_back(pick_byte());
    set_length(32'd1);
    payload_q.push_back(8'h7E);

    // Lengths just over and exactly at the block size, at full rate.
    set_length(zsbf_pkg::MaxBlock + 32'd1);
    gap_mode = IdleNone;
    stall_mode = IdleNone;
    for (int i = 0; i < 4; i++) payload_q.push_back(pick_byte());
    set_length(32'd1);
    payload_q.push_back(pick_byte());
    set_length(zsbf_pkg::MaxBlock);
    for (int i = 0; i < 4; i++) payload_q.push_back(pick_byte());

    // Random lengths and payloads, streams often left open across a rewrite.
    random_items = 0;
    while (random_items < RandomItems) begin
      case ($urandom_range(0, 9))
        0:       len = 32'd0;
        1:       len = 32'hFFFF_FFFF;
        2:       len = $urandom();
        default: len = $urandom_range(1, 12);
      endcase
      set_length(len);
      gap_mode = $urandom_range(IdleNone, IdleMixed);
      stall_mode = $urandom_range(IdleNone, IdleMixed);
      n = $urandom_range(1, 20);
      k = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n) : n;
      for (int i = 0; i < n; i++) begin
        if (i == k) wait_drained();
        payload_q.push_back(pick_byte());
      end
      random_items += n;
    end

    wait_drained();
    repeat (10) @(negedge clk);
    $display("sent %0d payload bytes, %0d streams closed, %0d stream bytes checked",
             bytes_sent, streams_done, bytes_checked);
    $display("%0d length writes, zero, all-ones and block-size lengths included",
             length_writes);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ zlib_stored_block_framer.f @@
hdl/zsbf_pkg.sv
hdl/zsbf_front.sv
hdl/zsbf_fifo.sv
hdl/zsbf_back.sv
hdl/zlib_stored_block_framer.sv
tb/sv/testbench.sv
